FILE: hdl/ikp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ikp_pkg;

  localparam int APB_AW    = 4;
  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int ACC_W     = 67;
  localparam int RES_MAX   = 8;
  localparam int B_COL_CAP = 8;
  localparam int IDENT_CAP = 31;
  localparam int OUT_DEPTH = 16;
  localparam int OUT_AW    = 4;

  localparam logic REQ_LOAD_B = 1'b0;
  localparam logic REQ_C_ELEM = 1'b1;

  typedef enum logic [1:0] {
    REG_ROWS_B,
    REG_COLS_B,
    REG_IDENT_SIZE,
    REG_C_COLS
  } reg_idx_e;

  typedef struct packed {
    logic              req_type;
    logic [2:0]        b_row;
    logic [2:0]        b_col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [6:0]         out_row;
    logic [11:0]        out_col;
    logic               last_of_run;
    logic               last_of_column;
    logic               last_of_matrix;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  rows_b;
    logic [3:0]  cols_b;
    logic [4:0]  ident_size;
    logic [12:0] c_cols;
    logic        wr;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  out_row;
    logic [11:0] out_col;
    logic        last_run;
    logic        last_col;
    logic        last_mat;
  } tag_t;

  typedef struct packed {
    logic valid;
    logic clr;
    tag_t tag;
  } issue_t;

endpackage

`default_nettype wire

FILE: hdl/ikp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ikp_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ikp_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output ikp_pkg::cfg_t                   cfg_o
);
  import ikp_pkg::*;

  logic [3:0]  rows_q, cols_q;
  logic [4:0]  ident_q;
  logic [12:0] ccols_q;
  logic        wr;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 4'd1;
      cols_q  <= 4'd1;
      ident_q <= 5'd1;
      ccols_q <= 13'd1;
    end else if (wr) begin
      case (idx)
        REG_ROWS_B:     rows_q  <= pwdata[3:0];
        REG_COLS_B:     cols_q  <= pwdata[3:0];
        REG_IDENT_SIZE: ident_q <= pwdata[4:0];
        REG_C_COLS:     ccols_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROWS_B:     prdata = {28'd0, rows_q};
      REG_COLS_B:     prdata = {28'd0, cols_q};
      REG_IDENT_SIZE: prdata = {27'd0, ident_q};
      REG_C_COLS:     prdata = {19'd0, ccols_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = '{rows_b: rows_q, cols_b: cols_q, ident_size: ident_q,
                   c_cols: ccols_q, wr: wr};

endmodule

`default_nettype wire

FILE: hdl/ikp_mac_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module ikp_mac_pipe #(
  parameter int ER  = 8,
  parameter int BD  = 64,
  parameter int RW  = 3,
  parameter int BAW = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 clr_acc_i,
  input  wire logic                 b_we_i,
  input  wire logic [BAW-1:0]       b_waddr_i,
  input  wire logic [31:0]          b_wdata_i,
  input  wire ikp_pkg::issue_t      issue_i,
  input  wire logic [RW-1:0]        row_i,
  input  wire logic [BAW-1:0]       b_raddr_i,
  input  wire logic signed [31:0]   c_i,
  output logic                      busy_o,
  output logic                      res_valid_o,
  output ikp_pkg::out_item_t        res_o
);
  import ikp_pkg::*;

  localparam int SAT_LO = VAL_W + FRAC_W - 1;

  logic [31:0]              b_mem   [BD];
  logic [ACC_W-1:0]         acc_mem [ER];
  logic [ER-1:0]            acc_vld_q;

  issue_t                   s1_q, s2_q;
  logic                     s3_v_q;
  tag_t                     s3_tag_q;
  logic [RW-1:0]            s1_row_q, s2_row_q;
  logic signed [31:0]       b_rd_q;
  logic signed [ACC_W-1:0]  acc_rd_q, acc_s2_q, sum_q;
  logic                     s1_av_q;
  logic signed [63:0]       prod_q;
  logic signed [ACC_W-1:0]  sum;
  logic [ACC_W:0]           rnd;
  logic                     fits;

  assign sum = acc_s2_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s2_q      <= '0;
      s3_v_q    <= 1'b0;
      acc_vld_q <= '0;
    end else begin
      s1_q   <= issue_i;
      s2_q   <= s1_q;
      s3_v_q <= s2_q.valid && s2_q.clr;
      if (clr_acc_i) begin
        acc_vld_q <= '0;
      end else if (s2_q.valid) begin
        acc_vld_q[s2_row_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      b_mem[b_waddr_i] <= b_wdata_i;
    end
    if (issue_i.valid) begin
      b_rd_q   <= b_mem[b_raddr_i];
      acc_rd_q <= acc_mem[row_i];
      s1_av_q  <= acc_vld_q[row_i];
    end
    if (s2_q.valid) begin
      acc_mem[s2_row_q] <= s2_q.clr ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= row_i;
    s2_row_q <= s1_row_q;
    prod_q   <= b_rd_q * c_i;
    acc_s2_q <= s1_av_q ? acc_rd_q : '0;
    sum_q    <= sum;
    s3_tag_q <= s2_q.tag;
  end

  // round half up, then clip to Q16.16
  assign rnd  = (ACC_W+1)'(sum_q) + (ACC_W+1)'(32'h8000);
  assign fits = (&rnd[ACC_W:SAT_LO]) || !(|rnd[ACC_W:SAT_LO]);

  always_comb begin
    res_o.out_row        = s3_tag_q.out_row;
    res_o.out_col        = s3_tag_q.out_col;
    res_o.last_of_run    = s3_tag_q.last_run;
    res_o.last_of_column = s3_tag_q.last_col;
    res_o.last_of_matrix = s3_tag_q.last_mat;
    res_o.saturated      = !fits;
    if (fits) begin
      res_o.out_value = rnd[SAT_LO:FRAC_W];
    end else if (rnd[ACC_W]) begin
      res_o.out_value = 32'sh8000_0000;
    end else begin
      res_o.out_value = 32'sh7FFF_FFFF;
    end
  end

  assign res_valid_o = s3_v_q;
  assign busy_o      = s1_q.valid || s2_q.valid || s3_v_q;

endmodule

`default_nettype wire

FILE: hdl/ikp_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ikp_out_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire ikp_pkg::out_item_t    push_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ikp_pkg::out_item_t         out_data_o,
  output logic [ikp_pkg::OUT_AW:0]   count_o
);
  import ikp_pkg::*;

  out_item_t         mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_AW:0]   cnt_q;
  logic              pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem[rd_ptr_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/identity_kron_matrix_product.sv
// A C item that ends a run yields one result per B row. The results pass the pipeline
// stages s1, s2 and s3 and enter the output queue one per cycle. Per C item, the
// accumulator memory is read, multiplied, added and written back one B row per cycle.
// A new item is taken only after the pipeline drains; a B load is stored when taken.
// Results wait in a 16-entry output queue; an item is taken while eight places are free.
// Reset: registers read 1, job counters and accumulators are zero, B store is undefined.
`timescale 1ns / 1ps
`default_nettype none

module identity_kron_matrix_product #(
  parameter int MAX_B_ROWS = 8,
  parameter int MAX_B_COLS = 8,
  parameter int MAX_IDENT  = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ikp_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire ikp_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output ikp_pkg::out_item_t              out_data_o
);
  import ikp_pkg::*;

  localparam int ER  = (MAX_B_ROWS < RES_MAX) ? MAX_B_ROWS : RES_MAX;
  localparam int EC  = (MAX_B_COLS < B_COL_CAP) ? MAX_B_COLS : B_COL_CAP;
  localparam int IE  = (MAX_IDENT < IDENT_CAP) ? MAX_IDENT : IDENT_CAP;
  localparam int RW  = (ER > 1) ? $clog2(ER) : 1;
  localparam int CW  = (EC > 1) ? $clog2(EC) : 1;
  localparam int BD  = ER * EC;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int BLW = (IE > 1) ? $clog2(IE) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_e;

  state_e             state_q;
  cfg_t               cfg;
  issue_t             issue;
  out_item_t          res;
  logic               res_valid, mac_busy, in_acc, b_we, last_row;
  logic               end_run, end_col, end_mat;
  logic [OUT_AW:0]    fifo_cnt;
  logic [3:0]         rb_eff, cb_eff;
  logic [4:0]         is_eff;
  logic [12:0]        cc_eff;
  logic [RW-1:0]      row_q;
  logic [CW-1:0]      pos_q, p_q;
  logic [BLW-1:0]     blk_q, iblk_q;
  logic [11:0]        col_q, icol_q;
  logic               clr_q, ecol_q, emat_q;
  logic signed [31:0] c_q;
  logic [BAW-1:0]     b_waddr, b_raddr;

  ikp_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  always_comb begin
    rb_eff = (cfg.rows_b == '0) ? 4'd1 :
             (cfg.rows_b > 4'(ER)) ? 4'(ER) : cfg.rows_b;
    cb_eff = (cfg.cols_b == '0) ? 4'd1 :
             (cfg.cols_b > 4'(EC)) ? 4'(EC) : cfg.cols_b;
    is_eff = (cfg.ident_size == '0) ? 5'd1 :
             (cfg.ident_size > 5'(IE)) ? 5'(IE) : cfg.ident_size;
    cc_eff = (cfg.c_cols == '0) ? 13'd1 :
             (cfg.c_cols > 13'd4096) ? 13'd4096 : cfg.c_cols;
  end

  assign end_run  = 4'(pos_q) + 4'd1 >= cb_eff;
  assign end_col  = 6'(blk_q) + 6'd1 >= {1'b0, is_eff};
  assign end_mat  = end_col && (13'(col_q) + 13'd1 >= cc_eff);
  assign last_row = 4'(row_q) + 4'd1 == rb_eff;

  assign in_ready_o = (state_q == ST_IDLE) && !mac_busy &&
                      (fifo_cnt <= (OUT_AW+1)'(OUT_DEPTH - RES_MAX));
  assign in_acc     = in_valid_i && in_ready_o;
  assign b_we       = in_acc && (in_data_i.req_type == REQ_LOAD_B) &&
                      (int'(in_data_i.b_row) < ER) && (int'(in_data_i.b_col) < EC);
  assign b_waddr    = BAW'(int'(in_data_i.b_row) * EC + int'(in_data_i.b_col));
  assign b_raddr    = BAW'(int'(row_q) * EC + int'(p_q));

  always_comb begin
    issue.valid        = state_q == ST_ISSUE;
    issue.clr          = clr_q;
    issue.tag.out_row  = 7'(12'(iblk_q) * 12'(rb_eff) + 12'(row_q));
    issue.tag.out_col  = icol_q;
    issue.tag.last_run = last_row;
    issue.tag.last_col = last_row && ecol_q;
    issue.tag.last_mat = last_row && emat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      pos_q   <= '0;
      blk_q   <= '0;
      col_q   <= '0;
      p_q     <= '0;
      iblk_q  <= '0;
      icol_q  <= '0;
      clr_q   <= 1'b0;
      ecol_q  <= 1'b0;
      emat_q  <= 1'b0;
      c_q     <= '0;
    end else if (cfg.wr) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      blk_q   <= '0;
      col_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.req_type == REQ_C_ELEM) begin
            state_q <= ST_ISSUE;
            row_q   <= '0;
            c_q     <= in_data_i.value;
            p_q     <= pos_q;
            iblk_q  <= blk_q;
            icol_q  <= col_q;
            clr_q   <= end_run;
            ecol_q  <= end_col;
            emat_q  <= end_mat;
            if (!end_run) begin
              pos_q <= pos_q + 1'b1;
            end else begin
              pos_q <= '0;
              if (end_col) begin
                blk_q <= '0;
                col_q <= end_mat ? '0 : col_q + 1'b1;
              end else begin
                blk_q <= blk_q + 1'b1;
              end
            end
          end
        end
        ST_ISSUE: begin
          row_q <= row_q + 1'b1;
          if (last_row) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  ikp_mac_pipe #(
    .ER  (ER),
    .BD  (BD),
    .RW  (RW),
    .BAW (BAW)
  ) u_mac (
    .clk_i,
    .rst_ni,
    .clr_acc_i   (cfg.wr),
    .b_we_i      (b_we),
    .b_waddr_i   (b_waddr),
    .b_wdata_i   (in_data_i.value),
    .issue_i     (issue),
    .row_i       (row_q),
    .b_raddr_i   (b_raddr),
    .c_i         (c_q),
    .busy_o      (mac_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ikp_out_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (res_valid),
    .push_data_i (res),
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .count_o     (fifo_cnt)
  );

  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !(out_valid_o && out_ready_i) |-> fifo_cnt < (OUT_AW+1)'(OUT_DEPTH))
    else $error("output queue overflow");

  a_mat_ends_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_matrix |-> out_data_o.last_of_column)
    else $error("matrix end without column end");

  a_col_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_column |-> out_data_o.last_of_run)
    else $error("column end without run end");

  a_issue_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.req_type == REQ_C_ELEM |=> issue.valid && !mac_busy)
    else $error("issue overlaps pipeline");

endmodule

`default_nettype wire
